// ===== rtl/bdv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bdv_pkg;

	localparam int FRAME_DEPTH = 256;
	localparam int FRAME_AW = $clog2(FRAME_DEPTH);
	localparam int COUNT_W = FRAME_AW + 1;
	localparam logic [7:0] MAX_NESTING_RST = 8'd200;

	localparam logic [3:0] V_OK = 4'd0;
	localparam logic [3:0] V_TRUNC = 4'd1;
	localparam logic [3:0] V_BAD_BOOL = 4'd2;
	localparam logic [3:0] V_UNTERM_STR = 4'd3;
	localparam logic [3:0] V_BAD_BIN = 4'd4;
	localparam logic [3:0] V_BAD_TYPE = 4'd5;
	localparam logic [3:0] V_LEN_MISMATCH = 4'd6;
	localparam logic [3:0] V_TOO_DEEP = 4'd7;
	localparam logic [3:0] V_UNNESTED = 4'd8;
	localparam logic [3:0] V_STR_SIZE = 4'd9;
	localparam logic [3:0] V_SHORT = 4'd10;

	localparam logic [7:0] T_DOUBLE = 8'h01;
	localparam logic [7:0] T_STRING = 8'h02;
	localparam logic [7:0] T_OBJECT = 8'h03;
	localparam logic [7:0] T_ARRAY = 8'h04;
	localparam logic [7:0] T_BINARY = 8'h05;
	localparam logic [7:0] T_UNDEF = 8'h06;
	localparam logic [7:0] T_OID = 8'h07;
	localparam logic [7:0] T_BOOL = 8'h08;
	localparam logic [7:0] T_DATE = 8'h09;
	localparam logic [7:0] T_NULL = 8'h0A;
	localparam logic [7:0] T_REGEX = 8'h0B;
	localparam logic [7:0] T_DBPTR = 8'h0C;
	localparam logic [7:0] T_CODE = 8'h0D;
	localparam logic [7:0] T_SYMBOL = 8'h0E;
	localparam logic [7:0] T_CWS = 8'h0F;
	localparam logic [7:0] T_INT32 = 8'h10;
	localparam logic [7:0] T_TSTAMP = 8'h11;
	localparam logic [7:0] T_INT64 = 8'h12;
	localparam logic [7:0] T_DEC128 = 8'h13;
	localparam logic [7:0] T_MAXKEY = 8'h7F;
	localparam logic [7:0] T_MINKEY = 8'hFF;

	typedef struct packed {
		logic [31:0] end_pos;
		logic        scoped;
		logic [31:0] scope_end;
	} frame_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		logic   clear;
		frame_t data;
	} stack_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/bdv_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bdv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface bdv_verdict_if;
	logic        valid;
	logic        ready;
	logic [3:0]  verdict;
	logic [31:0] verdict_offset;
	modport source(output valid, verdict, verdict_offset, input ready);
	modport sink(input valid, verdict, verdict_offset, output ready);
endinterface

interface bdv_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdv_frame_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdv_frame_stack
	import bdv_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  stack_cmd_t cmd,
	output frame_t     below
);

	frame_t mem [FRAME_DEPTH];
	logic [FRAME_AW-1:0] n_q, n_d, rd_addr;
	frame_t rd_q, fwd_data_q;
	logic fwd_q;

	always_comb begin
		n_d = n_q;
		if (cmd.clear) begin
			n_d = '0;
		end else if (cmd.push) begin
			n_d = n_q + 1'b1;
		end else if (cmd.pop) begin
			n_d = n_q - 1'b1;
		end
		rd_addr = n_d - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			fwd_q <= 1'b0;
		end else begin
			n_q <= n_d;
			fwd_q <= cmd.push && !cmd.clear && (rd_addr == n_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !cmd.clear) begin
			mem[n_q] <= cmd.data;
		end
		rd_q <= mem[rd_addr];
		fwd_data_q <= cmd.data;
	end

	assign below = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

// ===== rtl/bson_document_validator_unit.sv =====
// channel      | dir | payload
// byte_in      | in  | data_byte[7:0], last_byte
// verdict_out  | out | verdict[3:0], verdict_offset[31:0]
// cfg          | in  | data[7:0] -> max_nesting
//
// one byte per cycle while byte_in is ready, verdict registered and valid in the cycle after its byte
// frame stack top lives in flops, lower frames in a sync ram
// ram read is prefetched for the next pop, push-then-pop is forwarded
// byte_in stalls only while a verdict waits and verdict_out is not ready
// reset: max_nesting 200, parser waits for a document length prefix
`timescale 1ns / 1ps
`default_nettype none
module bson_document_validator_unit
	import bdv_pkg::*;
(
	input wire clk,
	input wire arst_n,
	bdv_byte_if.sink      byte_in,
	bdv_verdict_if.source verdict_out,
	bdv_cfg_if.sink       cfg
);

	typedef enum logic [10:0] {
		PH_LEN     = 11'b00000000001,
		PH_TYPE    = 11'b00000000010,
		PH_NAME    = 11'b00000000100,
		PH_SKIP    = 11'b00000001000,
		PH_BOOL    = 11'b00000010000,
		PH_STRLEN  = 11'b00000100000,
		PH_STRBODY = 11'b00001000000,
		PH_CSTR1   = 11'b00010000000,
		PH_CSTR2   = 11'b00100000000,
		PH_BINLEN  = 11'b01000000000,
		PH_CWSLEN  = 11'b10000000000
	} phase_t;

	phase_t ph_q, ph_d;
	logic [31:0] pos_q, pos_d, skip_q, skip_d, num_q, num_d;
	logic [7:0] kind_q, kind_d, max_q;
	frame_t top_q, top_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic given_q, given_d;
	logic out_valid_q;
	logic [3:0] out_code_q;
	logic [31:0] out_pos_q;

	stack_cmd_t cmd;
	frame_t below;

	logic acc, hit;
	logic [3:0] code;
	logic [7:0] b;
	logic [31:0] pos, skip_dec, num_new;
	logic [1:0] sel;
	logic num_done, deep;

	bdv_frame_stack u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.below(below)
	);

	assign byte_in.ready = !out_valid_q || verdict_out.ready;
	assign acc = byte_in.valid && byte_in.ready;
	assign cfg.ready = 1'b1;
	assign verdict_out.valid = out_valid_q;
	assign verdict_out.verdict = out_code_q;
	assign verdict_out.verdict_offset = out_pos_q;

	assign b = byte_in.data_byte;
	assign pos = pos_q + 32'd1;
	assign sel = 2'(2'd0 - skip_q[1:0]);
	assign num_new = num_q | ({24'd0, b} << {sel, 3'b000});
	assign skip_dec = (skip_q == 32'd0) ? 32'd0 : skip_q - 32'd1;
	assign num_done = (skip_dec == 32'd0);
	assign deep = (cnt_q > {1'b0, max_q}) || (cnt_q >= COUNT_W'(FRAME_DEPTH));

	always_comb begin
		ph_d = ph_q;
		pos_d = pos_q;
		skip_d = skip_q;
		num_d = num_q;
		kind_d = kind_q;
		top_d = top_q;
		cnt_d = cnt_q;
		given_d = given_q;
		cmd = '{push: 1'b0, pop: 1'b0, clear: 1'b0, data: top_q};
		hit = 1'b0;
		code = V_OK;
		if (acc) begin
			pos_d = pos;
			if (!given_q) begin
				unique case (ph_q)
					PH_LEN, PH_CWSLEN: begin
						num_d = num_new;
						skip_d = skip_dec;
						if (num_done) begin
							top_d.end_pos = top_q.end_pos + num_new;
							if (ph_q == PH_LEN) begin
								ph_d = PH_TYPE;
							end else begin
								skip_d = 32'd4;
								num_d = '0;
								ph_d = PH_STRLEN;
							end
						end
					end
					PH_TYPE: begin
						if (b == 8'd0) begin
							if (top_q.end_pos != pos) begin
								hit = 1'b1;
								code = V_LEN_MISMATCH;
							end else if (top_q.scoped) begin
								if (top_q.scope_end != pos) begin
									hit = 1'b1;
									code = V_LEN_MISMATCH;
								end else begin
									cnt_d = cnt_q - COUNT_W'(2);
									if (cnt_q == COUNT_W'(2)) begin
										hit = 1'b1;
										code = V_UNNESTED;
									end else begin
										cmd.pop = 1'b1;
										top_d = below;
										ph_d = PH_TYPE;
									end
								end
							end else begin
								cnt_d = cnt_q - COUNT_W'(1);
								if (cnt_q == COUNT_W'(1)) begin
									hit = 1'b1;
									code = V_OK;
								end else begin
									cmd.pop = 1'b1;
									top_d = below;
									ph_d = PH_TYPE;
								end
							end
						end else begin
							kind_d = b;
							ph_d = PH_NAME;
						end
					end
					PH_NAME: begin
						if (b == 8'd0) begin
							case (kind_q) inside
								T_MINKEY, T_MAXKEY, T_NULL, T_UNDEF: ph_d = PH_TYPE;
								T_OID: begin
									skip_d = 32'd12;
									ph_d = PH_SKIP;
								end
								T_INT32: begin
									skip_d = 32'd4;
									ph_d = PH_SKIP;
								end
								T_BOOL: ph_d = PH_BOOL;
								T_DOUBLE, T_INT64, T_TSTAMP, T_DATE: begin
									skip_d = 32'd8;
									ph_d = PH_SKIP;
								end
								T_DEC128: begin
									skip_d = 32'd16;
									ph_d = PH_SKIP;
								end
								T_DBPTR, T_CODE, T_SYMBOL, T_STRING: begin
									skip_d = 32'd4;
									num_d = '0;
									ph_d = PH_STRLEN;
								end
								T_REGEX: ph_d = PH_CSTR1;
								T_BINARY: begin
									skip_d = 32'd4;
									num_d = '0;
									ph_d = PH_BINLEN;
								end
								T_CWS: begin
									if (cnt_q >= COUNT_W'(FRAME_DEPTH)) begin
										hit = 1'b1;
										code = V_TOO_DEEP;
									end else begin
										cmd.push = 1'b1;
										top_d = '{end_pos: pos, scoped: 1'b0, scope_end: '0};
										cnt_d = cnt_q + COUNT_W'(1);
										skip_d = 32'd4;
										num_d = '0;
										ph_d = PH_CWSLEN;
									end
								end
								T_OBJECT, T_ARRAY: begin
									if (deep) begin
										hit = 1'b1;
										code = V_TOO_DEEP;
									end else begin
										cmd.push = 1'b1;
										top_d = '{end_pos: pos, scoped: 1'b0, scope_end: '0};
										cnt_d = cnt_q + COUNT_W'(1);
										skip_d = 32'd4;
										num_d = '0;
										ph_d = PH_LEN;
									end
								end
								default: begin
									hit = 1'b1;
									code = V_BAD_TYPE;
								end
							endcase
						end
					end
					PH_SKIP: begin
						skip_d = skip_dec;
						if (skip_dec == 32'd0) begin
							ph_d = PH_TYPE;
						end
					end
					PH_BOOL: begin
						if (b > 8'd1) begin
							hit = 1'b1;
							code = V_BAD_BOOL;
						end else begin
							ph_d = PH_TYPE;
						end
					end
					PH_STRLEN: begin
						num_d = num_new;
						skip_d = skip_dec;
						if (num_done) begin
							if (num_new == 32'd0 || num_new[31]) begin
								hit = 1'b1;
								code = V_STR_SIZE;
							end else begin
								skip_d = num_new - 32'd1;
								ph_d = PH_STRBODY;
							end
						end
					end
					PH_STRBODY: begin
						if (skip_q != 32'd0) begin
							skip_d = skip_q - 32'd1;
						end else if (b != 8'd0) begin
							hit = 1'b1;
							code = V_UNTERM_STR;
						end else if (kind_q == T_DBPTR) begin
							skip_d = 32'd12;
							ph_d = PH_SKIP;
						end else if (kind_q == T_CWS) begin
							if (deep) begin
								hit = 1'b1;
								code = V_TOO_DEEP;
							end else begin
								top_d = '{end_pos: pos, scoped: 1'b1, scope_end: top_q.end_pos};
								cnt_d = cnt_q + COUNT_W'(1);
								skip_d = 32'd4;
								num_d = '0;
								ph_d = PH_LEN;
							end
						end else begin
							ph_d = PH_TYPE;
						end
					end
					PH_CSTR1: begin
						if (b == 8'd0) begin
							ph_d = PH_CSTR2;
						end
					end
					PH_CSTR2: begin
						if (b == 8'd0) begin
							ph_d = PH_TYPE;
						end
					end
					PH_BINLEN: begin
						num_d = num_new;
						skip_d = skip_dec;
						if (num_done) begin
							if (num_new[31] || num_new == 32'h7FFF_FFFF) begin
								hit = 1'b1;
								code = V_BAD_BIN;
							end else begin
								skip_d = num_new + 32'd1;
								ph_d = PH_SKIP;
							end
						end
					end
					default: ph_d = PH_TYPE;
				endcase
				if (!hit && byte_in.last_byte) begin
					hit = 1'b1;
					code = (pos < 32'd5) ? V_SHORT : V_TRUNC;
				end
			end
			if (hit) begin
				given_d = 1'b1;
			end
			if (byte_in.last_byte) begin
				pos_d = '0;
				kind_d = '0;
				top_d = '{end_pos: '0, scoped: 1'b0, scope_end: '0};
				cnt_d = COUNT_W'(1);
				given_d = 1'b0;
				skip_d = 32'd4;
				num_d = '0;
				ph_d = PH_LEN;
				cmd.clear = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LEN;
			pos_q <= '0;
			skip_q <= 32'd4;
			num_q <= '0;
			kind_q <= '0;
			top_q <= '{end_pos: '0, scoped: 1'b0, scope_end: '0};
			cnt_q <= COUNT_W'(1);
			given_q <= 1'b0;
			max_q <= MAX_NESTING_RST;
			out_valid_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			pos_q <= pos_d;
			skip_q <= skip_d;
			num_q <= num_d;
			kind_q <= kind_d;
			top_q <= top_d;
			cnt_q <= cnt_d;
			given_q <= given_d;
			if (cfg.valid) begin
				max_q <= cfg.data;
			end
			if (acc && hit) begin
				out_valid_q <= 1'b1;
			end else if (verdict_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hit) begin
			out_code_q <= code;
			out_pos_q <= pos;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bdv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdv_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [3:0]  verdict,
	input wire [31:0] verdict_offset
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(verdict_offset))
		else $error("verdict word dropped or changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("byte input stalled without a waiting verdict");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= 4'd10)
		else $error("verdict code out of range");

	a_short_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == 4'd10 |-> verdict_offset < 32'd5)
		else $error("short buffer verdict at offset five or more");

endmodule

bind bson_document_validator_unit bdv_checker u_bdv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(byte_in.ready),
	.out_valid(verdict_out.valid),
	.out_ready(verdict_out.ready),
	.verdict(verdict_out.verdict),
	.verdict_offset(verdict_out.verdict_offset)
);
`default_nettype wire
